>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL modules of the backlight level write sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clk edge outside reset.
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clk edge outside reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/bls_pkg.sv
// Types and constants shared by the backlight level write sequencer modules.
package bls_pkg;

  // Configuration register indexes
  localparam logic CFG_CABC_ENABLE = 1'b0;
  localparam logic CFG_LUT_SELECT  = 1'b1;

  // Curve segment starts
  localparam logic [7:0] SEG1_START = 8'd140;
  localparam logic [7:0] SEG2_START = 8'd30;
  localparam logic [7:0] SEG3_START = 8'd20;

  // Reciprocals for 2^20 scaling: level = ((n * m) >> 20) + offset
  localparam int unsigned RECIP_SHIFT = 20;
  localparam logic [18:0] M_SEG1 = 19'd9119;    // 1/115
  localparam logic [18:0] M_SEG2 = 19'd19066;   // 1/55
  localparam logic [18:0] M_SEG3 = 19'd104858;  // 1/10
  localparam logic [18:0] M_SEG4 = 19'd262144;  // 1/4
  localparam logic [6:0]  OFF_SEG1 = 7'd32;
  localparam logic [6:0]  OFF_SEG2 = 7'd8;
  localparam logic [6:0]  OFF_SEG3 = 7'd5;
  localparam logic [6:0]  OFF_SEG4 = 7'd0;

  // Reciprocal of 100 with the same 2^20 scaling
  localparam logic [13:0] M_PCT = 14'd10486;

  localparam logic [6:0] LEVEL_RESET = 7'd32;

  // Power scaling table
  localparam int unsigned LUT_ITEMS = 9;
  localparam logic [7:0] POWER_TABLE [0:3][0:LUT_ITEMS-1] = '{
    '{8'h3e, 8'h43, 8'h3a, 8'h48, 8'h3e, 8'h3b, 8'h36, 8'h33, 8'h3b},
    '{8'h3e, 8'h43, 8'h3a, 8'h48, 8'h3e, 8'h3b, 8'h36, 8'h33, 8'h3b},
    '{8'h3e, 8'h43, 8'h3a, 8'h48, 8'h3e, 8'h3b, 8'h36, 8'h33, 8'h3b},
    '{8'h3e, 8'h43, 8'h3a, 8'h48, 8'h3e, 8'h3b, 8'h36, 8'h33, 8'h3b}
  };

  // Register addresses and fixed data
  localparam logic [7:0]  ADDR_BANK     = 8'h00;
  localparam logic [7:0]  ADDR_LUT_BASE = 8'h76;
  localparam logic [7:0]  ADDR_PWM      = 8'hB4;
  localparam logic [7:0]  ADDR_COMMIT   = 8'h28;
  localparam logic [15:0] PWM_CABC      = 16'h5000;
  localparam logic [15:0] PWM_MANUAL    = 16'h4000;

  // Write steps of one run
  localparam logic [2:0] STEP_BANK   = 3'd0;
  localparam logic [2:0] STEP_LUT0   = 3'd1;
  localparam logic [2:0] STEP_LUT1   = 3'd2;
  localparam logic [2:0] STEP_LUT2   = 3'd3;
  localparam logic [2:0] STEP_LUT3   = 3'd4;
  localparam logic [2:0] STEP_LUT4   = 3'd5;
  localparam logic [2:0] STEP_PWM    = 3'd6;
  localparam logic [2:0] STEP_COMMIT = 3'd7;

  // Request held in the queue between front and back
  typedef struct packed {
    logic [6:0]  level;
    logic [19:0] level_pct;  // level * M_PCT, feeds the table scaling
  } entry_t;

endpackage

>>> rtl/bls_front.sv
// Front end: accepts intensity requests and maps them to a level through the curve.
`include "assert_macros.svh"

module bls_front #(
  parameter int unsigned QUEUE_DEPTH = 4,
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_push,
  input  logic [7:0]      in_intensity,
  output logic            in_full,
  input  logic [CW-1:0]   q_count,
  output logic            q_push,
  output bls_pkg::entry_t q_wdata
);
  import bls_pkg::*;

  localparam int unsigned OW = $clog2(QUEUE_DEPTH + 4);

  logic        s1_valid_r, s2_valid_r, s3_valid_r;
  logic [12:0] n_r, n_nxt;
  logic [18:0] m_r, m_nxt;
  logic [6:0]  off_r, off_nxt;
  logic [5:0]  q_r;
  logic [6:0]  off2_r;
  logic [6:0]  level_r;
  logic [7:0]  d_w;
  logic [31:0] prod_w;
  logic [20:0] pct_w;
  logic [OW-1:0] occ_w;
  logic        accept_w;

  // Room check counts requests still in the pipeline
  assign occ_w = OW'(q_count) + OW'(s1_valid_r) + OW'(s2_valid_r) + OW'(s3_valid_r);
  assign in_full  = (occ_w >= OW'(QUEUE_DEPTH));
  assign accept_w = in_push && !in_full;

  // Segment select: numerator, reciprocal and offset
  always_comb begin
    d_w = '0;
    if (in_intensity >= SEG1_START) begin
      d_w     = in_intensity - SEG1_START;
      n_nxt   = 13'({d_w, 5'b0}) + 13'({d_w, 4'b0});
      m_nxt   = M_SEG1;
      off_nxt = OFF_SEG1;
    end else if (in_intensity >= SEG2_START) begin
      d_w     = in_intensity - SEG2_START;
      n_nxt   = 13'({d_w, 3'b0}) + 13'({d_w, 2'b0});
      m_nxt   = M_SEG2;
      off_nxt = OFF_SEG2;
    end else if (in_intensity >= SEG3_START) begin
      d_w     = in_intensity - SEG3_START;
      n_nxt   = 13'({d_w, 1'b0}) + 13'(d_w);
      m_nxt   = M_SEG3;
      off_nxt = OFF_SEG3;
    end else begin
      n_nxt   = 13'(in_intensity);
      m_nxt   = M_SEG4;
      off_nxt = OFF_SEG4;
    end
  end

  assign prod_w = 32'(n_r) * 32'(m_r);
  assign pct_w  = 21'(level_r) * 21'(M_PCT);

  // Valid pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept_w;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  // Payload pipeline: operands, quotient, level
  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    m_r     <= m_nxt;
    off_r   <= off_nxt;
    q_r     <= prod_w[RECIP_SHIFT+5:RECIP_SHIFT];
    off2_r  <= off_r;
    level_r <= 7'(q_r) + off2_r;
  end

  assign q_push            = s3_valid_r;
  assign q_wdata.level     = level_r;
  assign q_wdata.level_pct = pct_w[19:0];

  `ASSERT_SAME(a_push_has_room, s3_valid_r, q_count < CW'(QUEUE_DEPTH), "queue push without room")

endmodule

>>> rtl/bls_queue.sv
// Short request queue between the front end and the write sequencer.
`include "assert_macros.svh"

module bls_queue #(
  parameter int unsigned QUEUE_DEPTH = 4,
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  bls_pkg::entry_t wdata,
  input  logic            pop,
  output bls_pkg::entry_t rdata,
  output logic            empty,
  output logic [CW-1:0]   count
);
  import bls_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  entry_t        mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  // Pointer and fill tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata = mem_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign count = count_r;

  `ASSERT_SAME(a_count_bound, 1'b1, count_r <= CW'(QUEUE_DEPTH), "queue count past depth")

endmodule

>>> rtl/bls_back.sv
// Write sequencer: expands each queued level into its run of register writes.
`include "assert_macros.svh"

module bls_back #(
  parameter int unsigned LUT_ROWS = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cabc_enable,
  input  logic            lut_select,
  input  bls_pkg::entry_t q_rdata,
  input  logic            q_empty,
  output logic            q_pop,
  output logic            out_empty,
  input  logic            out_pop,
  output logic [7:0]      out_reg_addr,
  output logic [15:0]     out_reg_data,
  output logic [6:0]      out_level,
  output logic            out_last
);
  import bls_pkg::*;

  logic        run_active_r;
  logic [2:0]  step_r, step_nxt;
  logic [6:0]  stored_level_r;
  logic [19:0] lm_r;
  logic        mode_r;
  logic [1:0]  row_r, row_nxt;
  logic        out_valid_r;
  logic [7:0]  out_addr_r, addr_nxt;
  logic [15:0] out_data_r, data_nxt;
  logic [6:0]  out_level_r;
  logic        out_last_r;
  logic        adv_w, load_w;
  logic [3:0]  hi_idx, lo_idx;
  logic        lo_en;
  logic [27:0] hi_p, lo_p;
  logic [7:0]  hi_s, lo_s;

  // Advance when the output register is free or being drained
  assign adv_w  = run_active_r && (!out_valid_r || out_pop);
  assign load_w = !q_empty && (!run_active_r || (adv_w && step_r == STEP_COMMIT));
  assign q_pop  = load_w;

  // Row saturates at the last table row
  assign row_nxt = (32'(lut_select) >= LUT_ROWS) ? 2'(LUT_ROWS - 1) : {1'b0, lut_select};

  // Table byte indexes for the power LUT words
  always_comb begin
    hi_idx = 4'd0;
    lo_idx = 4'd0;
    lo_en  = 1'b1;
    case (step_r)
      STEP_LUT0: begin hi_idx = 4'd0; lo_idx = 4'd1; end
      STEP_LUT1: begin hi_idx = 4'd2; lo_idx = 4'd3; end
      STEP_LUT2: begin hi_idx = 4'd4; lo_idx = 4'd5; end
      STEP_LUT3: begin hi_idx = 4'd6; lo_idx = 4'd7; end
      STEP_LUT4: begin hi_idx = 4'd8; lo_en = 1'b0; end
      default:   lo_en = 1'b0;
    endcase
  end

  // Scale by level / 100
  assign hi_p = 28'(POWER_TABLE[row_r][hi_idx]) * 28'(lm_r);
  assign lo_p = 28'(POWER_TABLE[row_r][lo_idx]) * 28'(lm_r);
  assign hi_s = hi_p[27:20];
  assign lo_s = lo_en ? lo_p[27:20] : 8'h00;

  // Write decoder
  always_comb begin
    unique case (step_r) inside
      STEP_BANK: begin
        addr_nxt = ADDR_BANK;
        data_nxt = 16'h0000;
      end
      STEP_LUT0, STEP_LUT1, STEP_LUT2, STEP_LUT3, STEP_LUT4: begin
        addr_nxt = ADDR_LUT_BASE + 8'(step_r) - 8'd1;
        data_nxt = {hi_s, lo_s};
      end
      STEP_PWM: begin
        addr_nxt = ADDR_PWM;
        data_nxt = (mode_r ? PWM_CABC : PWM_MANUAL) | {5'b0, stored_level_r, 4'b0};
      end
      STEP_COMMIT: begin
        addr_nxt = ADDR_COMMIT;
        data_nxt = 16'h0000;
      end
      default: begin
        addr_nxt = ADDR_BANK;
        data_nxt = 16'h0000;
      end
    endcase
  end

  // Manual mode skips the LUT words
  assign step_nxt = (step_r == STEP_BANK && !mode_r) ? STEP_PWM : step_r + 3'd1;

  // Run control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_active_r   <= 1'b0;
      step_r         <= STEP_BANK;
      stored_level_r <= LEVEL_RESET;
      out_valid_r    <= 1'b0;
    end else begin
      if (load_w) begin
        run_active_r   <= 1'b1;
        step_r         <= STEP_BANK;
        stored_level_r <= q_rdata.level;
      end else if (adv_w) begin
        if (step_r == STEP_COMMIT) begin
          run_active_r <= 1'b0;
        end else begin
          step_r <= step_nxt;
        end
      end
      if (adv_w) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Run payload and output register
  always_ff @(posedge clk) begin
    if (load_w) begin
      lm_r   <= q_rdata.level_pct;
      mode_r <= cabc_enable;
      row_r  <= row_nxt;
    end
    if (adv_w) begin
      out_addr_r  <= addr_nxt;
      out_data_r  <= data_nxt;
      out_level_r <= stored_level_r;
      out_last_r  <= (step_r == STEP_COMMIT);
    end
  end

  assign out_empty    = !out_valid_r;
  assign out_reg_addr = out_addr_r;
  assign out_reg_data = out_data_r;
  assign out_level    = out_level_r;
  assign out_last     = out_last_r;

  `ASSERT_SAME(a_no_pop_mid_run, run_active_r && !adv_w, !q_pop, "queue popped during a run")
  `ASSERT_NEXT(a_level_in_run, out_valid_r && out_pop && !out_last_r, out_level_r == $past(out_level_r), "level changed within a run")

endmodule

>>> rtl/backlight_level_write_sequencer.sv
// Top level of the backlight level write sequencer: config registers and block wiring.
//
// Each intensity request (0..255) is mapped through the four-segment brightness curve to a
// level of 0..80, which then drives a run of 16-bit register writes: three in manual mode
// (bank select, PWM duty, commit) and eight in CABC mode (bank select, five power-LUT words
// scaled by level/100, PWM duty, commit). The input side takes one request per cycle while
// the request queue has room; each request passes through the registered curve pipeline
// before it reaches the queue. The write sequencer emits one write per cycle while the
// receiver keeps popping, so the sustained request rate is set by the sequencer's write
// count per run. There is no clearing pass after reset.
module backlight_level_write_sequencer #(
  parameter int unsigned LUT_ROWS    = 2,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_data,
  // requests
  input  logic        in_push,
  input  logic [7:0]  in_intensity,
  output logic        in_full,
  // register writes
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_reg_addr,
  output logic [15:0] out_reg_data,
  output logic [6:0]  out_level,
  output logic        out_last
);
  import bls_pkg::*;

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic          cabc_enable_r;
  logic          lut_select_r;
  logic          q_push, q_pop, q_empty;
  entry_t        q_wdata, q_rdata;
  logic [CW-1:0] q_count;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cabc_enable_r <= 1'b0;
      lut_select_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CABC_ENABLE: cabc_enable_r <= cfg_data;
        CFG_LUT_SELECT:  lut_select_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  bls_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_intensity (in_intensity),
    .in_full      (in_full),
    .q_count      (q_count),
    .q_push       (q_push),
    .q_wdata      (q_wdata)
  );

  bls_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .count (q_count)
  );

  bls_back #(.LUT_ROWS(LUT_ROWS)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cabc_enable  (cabc_enable_r),
    .lut_select   (lut_select_r),
    .q_rdata      (q_rdata),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_reg_addr (out_reg_addr),
    .out_reg_data (out_reg_data),
    .out_level    (out_level),
    .out_last     (out_last)
  );

endmodule

>>> dv/tb_backlight_level_write_sequencer.sv
// Testbench for the backlight level write sequencer: random and directed requests checked
// against a scoreboard that predicts every register write.
`timescale 1ns / 100ps

module tb_backlight_level_write_sequencer;
  import bls_pkg::*;

  localparam int unsigned TB_LUT_ROWS = 2;
  localparam int unsigned IDLE_LIMIT  = 5000;
  localparam int unsigned STALL_CYCLES = 300;
  localparam int unsigned TAIL_CYCLES  = 16;

  // Register map of one write run
  localparam logic [7:0]  REG_BANK     = 8'h00;
  localparam logic [7:0]  REG_LUT_BASE = 8'h76;
  localparam logic [7:0]  REG_PWM      = 8'hB4;
  localparam logic [7:0]  REG_COMMIT   = 8'h28;
  localparam logic [15:0] DUTY_CABC    = 16'h5000;
  localparam logic [15:0] DUTY_MANUAL  = 16'h4000;
  localparam int unsigned TUNE_CLAMP   = 1600;

  localparam logic [7:0] POWER_BYTES [0:3][0:8] = '{
    '{8'h3e, 8'h43, 8'h3a, 8'h48, 8'h3e, 8'h3b, 8'h36, 8'h33, 8'h3b},
    '{8'h3e, 8'h43, 8'h3a, 8'h48, 8'h3e, 8'h3b, 8'h36, 8'h33, 8'h3b},
    '{8'h3e, 8'h43, 8'h3a, 8'h48, 8'h3e, 8'h3b, 8'h36, 8'h33, 8'h3b},
    '{8'h3e, 8'h43, 8'h3a, 8'h48, 8'h3e, 8'h3b, 8'h36, 8'h33, 8'h3b}
  };

  // Intensities sitting on the curve's segment edges
  localparam logic [7:0] EDGE_INTENSITIES [0:11] = '{
    8'd0, 8'd1, 8'd19, 8'd20, 8'd21, 8'd29, 8'd30, 8'd31, 8'd139, 8'd140, 8'd141, 8'd255
  };

  typedef struct {
    logic [7:0]  addr;
    logic [15:0] data;
    logic [6:0]  level;
    logic        wr_last;
  } reg_write_t;

  // Scoreboard: predicts the write run of each request and checks writes in order
  class write_scoreboard;
    bit          cabc_on;
    bit          lut_row_sel;
    logic [6:0]  held_level;
    int          errors;
    reg_write_t  pending_writes[$];

    function new();
      cabc_on     = 1'b0;
      lut_row_sel = 1'b0;
      held_level  = 7'd32;
      errors      = 0;
    endfunction

    function void set_register(logic idx, logic value);
      if (idx == CFG_CABC_ENABLE) cabc_on = value;
      else lut_row_sel = value;
    endfunction

    function int unsigned brightness_curve(int unsigned i);
      if (i >= 140) return (i - 140) * 768 / 115 + 512;
      if (i >= 30) return (i - 30) * 384 / 110 + 128;
      if (i >= 20) return (i - 20) * 48 / 10 + 80;
      return i * 80 / 20;
    endfunction

    function logic [7:0] pct_scale(logic [7:0] b, logic [6:0] lvl);
      int unsigned prod;
      prod = int'(b) * int'(lvl) / 100;
      return prod[7:0];
    endfunction

    function void push_write(logic [7:0] addr, logic [15:0] data, logic [6:0] lvl,
                             logic wr_last);
      reg_write_t w;
      w.addr    = addr;
      w.data    = data;
      w.level   = lvl;
      w.wr_last = wr_last;
      pending_writes.push_back(w);
    endfunction

    // Accepted request: work out the whole write run it causes
    function void note_request(logic [7:0] intensity);
      int unsigned tune;
      int unsigned row;
      logic [6:0]  lvl;
      logic [15:0] duty;
      tune = brightness_curve(intensity);
      if (tune > TUNE_CLAMP) tune = TUNE_CLAMP;
      lvl = 7'((tune >> 4) & 32'h7f);
      held_level = lvl;
      duty = {5'd0, lvl, 4'd0};
      push_write(REG_BANK, 16'h0000, lvl, 1'b0);
      if (cabc_on) begin
        row = 32'(lut_row_sel);
        if (row >= TB_LUT_ROWS) row = TB_LUT_ROWS - 1;
        for (int k = 0; k < 4; k++) begin
          push_write(REG_LUT_BASE + 8'(k),
                     {pct_scale(POWER_BYTES[row][2*k], lvl),
                      pct_scale(POWER_BYTES[row][2*k+1], lvl)}, lvl, 1'b0);
        end
        push_write(REG_LUT_BASE + 8'd4, {pct_scale(POWER_BYTES[row][8], lvl), 8'h00},
                   lvl, 1'b0);
        push_write(REG_PWM, DUTY_CABC | duty, lvl, 1'b0);
      end else begin
        push_write(REG_PWM, DUTY_MANUAL | duty, lvl, 1'b0);
      end
      push_write(REG_COMMIT, 16'h0000, lvl, 1'b1);
    endfunction

    // Accepted write: compare with the oldest predicted one
    function void check_write(logic [7:0] addr, logic [15:0] data, logic [6:0] lvl,
                              logic wr_last);
      reg_write_t w;
      if (pending_writes.size() == 0) begin
        $error("unexpected write: reg_addr %h reg_data %h", addr, data);
        errors++;
        return;
      end
      w = pending_writes.pop_front();
      if (addr !== w.addr) begin
        $error("reg_addr: expected %h, got %h", w.addr, addr);
        errors++;
      end
      if (data !== w.data) begin
        $error("reg_data: expected %h, got %h", w.data, data);
        errors++;
      end
      if (lvl !== w.level) begin
        $error("level: expected %0d, got %0d", w.level, lvl);
        errors++;
      end
      if (wr_last !== w.wr_last) begin
        $error("last: expected %0b, got %0b", w.wr_last, wr_last);
        errors++;
      end
    endfunction

    function int pending();
      return pending_writes.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic        cfg_data;
  logic        in_push;
  logic [7:0]  in_intensity;
  logic        in_full;
  logic        out_empty;
  logic        out_pop;
  logic [7:0]  out_reg_addr;
  logic [15:0] out_reg_data;
  logic [6:0]  out_level;
  logic        out_last;

  write_scoreboard sb;
  int unsigned idle_pct;
  bit          stall_req;
  int unsigned quiet_cycles;

  backlight_level_write_sequencer uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_push      (in_push),
    .in_intensity (in_intensity),
    .in_full      (in_full),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_reg_addr (out_reg_addr),
    .out_reg_data (out_reg_data),
    .out_level    (out_level),
    .out_last     (out_last)
  );

  // 4 ns clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Offer one request, with random idle cycles ahead of it, and wait for it to be taken
  task automatic send_request(input logic [7:0] intensity);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push      <= 1'b1;
    in_intensity <= intensity;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.note_request(intensity);
  endtask

  // Drop the request line and wait until every predicted write has come out
  task automatic drain();
    @(negedge clk);
    in_push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_register(idx, value);
  endtask

  // Receiver: random pop idling, plus one long hold-off on request
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_req) begin
        stall_left = STALL_CYCLES;
        stall_req  = 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty)
      sb.check_write(out_reg_addr, out_reg_data, out_level, out_last);
  end

  // Watchdog on cycles without any accepted request or write
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Main stimulus
  initial begin
    logic [7:0] manual_set[$];
    logic [7:0] cabc_set[$];
    logic [7:0] value;
    logic       cabc_sel;
    logic       lut_sel;

    manual_set = '{8'd0, 8'd1, 8'd19, 8'd20, 8'd29, 8'd30, 8'd139, 8'd140, 8'd255,
                   8'h55, 8'hAA};
    cabc_set   = '{8'd0, 8'd21, 8'd31, 8'd128, 8'd141, 8'd200, 8'd254, 8'd255,
                   8'hAA, 8'h55, 8'd64, 8'd100};
    sb           = new();
    idle_pct     = 6;
    stall_req    = 1'b0;
    quiet_cycles = 0;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_CABC_ENABLE;
    cfg_data     = 1'b0;
    in_push      = 1'b0;
    in_intensity = 8'd0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: manual path with reset configuration, then CABC path
    foreach (manual_set[i]) send_request(manual_set[i]);
    drain();
    write_register(CFG_CABC_ENABLE, 1'b1);
    write_register(CFG_LUT_SELECT, 1'b1);
    foreach (cabc_set[i]) send_request(cabc_set[i]);
    drain();

    // Random phases, each under its own register setting
    for (int p = 0; p < 8; p++) begin
      if (p < 4) begin
        cabc_sel = p[0];
        lut_sel  = p[1];
      end else begin
        cabc_sel = 1'($urandom_range(1));
        lut_sel  = 1'($urandom_range(1));
      end
      write_register(CFG_CABC_ENABLE, cabc_sel);
      write_register(CFG_LUT_SELECT, lut_sel);
      idle_pct = (p == 2) ? 0 : 6;
      // long receiver hold-off so the queue fills and backs up the input
      if (p == 5) stall_req = 1'b1;
      for (int n = 0; n < 60; n++) begin
        if ($urandom_range(4) == 0) value = EDGE_INTENSITIES[$urandom_range(11)];
        else value = 8'($urandom_range(255));
        send_request(value);
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
